[hw/rtl/bsm_pkg.sv]
// ----------------------------------------------------------------------------
// bsm_pkg: shared types and constants of the byte stack machine
// Item operation codes, status codes, opcode numbers and decode helpers.
// ----------------------------------------------------------------------------
package bsm_pkg;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_STEP  = 2'd2,
		OP_NONE  = 2'd3
	} item_op_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_RUNNING = 3'd1,
		ST_HALTED  = 3'd2,
		ST_ILLEGAL = 3'd3,
		ST_DIVZERO = 3'd4
	} status_t;

	localparam logic [7:0] OPC_HLT     = 8'd0;
	localparam logic [7:0] OPC_ADD     = 8'd1;
	localparam logic [7:0] OPC_SUB     = 8'd2;
	localparam logic [7:0] OPC_MUL     = 8'd3;
	localparam logic [7:0] OPC_DIV     = 8'd4;
	localparam logic [7:0] OPC_MOD     = 8'd5;
	localparam logic [7:0] OPC_NEG     = 8'd6;
	localparam logic [7:0] OPC_NOT     = 8'd7;
	localparam logic [7:0] OPC_OR      = 8'd8;
	localparam logic [7:0] OPC_XOR     = 8'd9;
	localparam logic [7:0] OPC_SHL     = 8'd10;
	localparam logic [7:0] OPC_SHR     = 8'd11;
	localparam logic [7:0] OPC_EQ      = 8'd12;
	localparam logic [7:0] OPC_NEQ     = 8'd13;
	localparam logic [7:0] OPC_LT      = 8'd14;
	localparam logic [7:0] OPC_LE      = 8'd15;
	localparam logic [7:0] OPC_GT      = 8'd16;
	localparam logic [7:0] OPC_GE      = 8'd17;
	localparam logic [7:0] OPC_JMP     = 8'd18;
	localparam logic [7:0] OPC_JMPREL  = 8'd19;
	localparam logic [7:0] OPC_JMPF    = 8'd20;
	localparam logic [7:0] OPC_JMPFREL = 8'd21;
	localparam logic [7:0] OPC_JMPT    = 8'd22;
	localparam logic [7:0] OPC_JMPTREL = 8'd23;
	localparam logic [7:0] OPC_IMM     = 8'd24;
	localparam logic [7:0] OPC_INV     = 8'd25;
	localparam logic [7:0] OPC_INVREL  = 8'd26;
	localparam logic [7:0] OPC_CPY     = 8'd27;
	localparam logic [7:0] OPC_ARG     = 8'd28;
	localparam logic [7:0] OPC_REP     = 8'd29;
	localparam logic [7:0] OPC_RET     = 8'd30;

	// Binary operators that pop two operands and push one result.
	function automatic logic is_binary(input logic [7:0] opc);
		return (opc >= OPC_ADD) && (opc <= OPC_GE) && (opc != OPC_NEG) && (opc != OPC_NOT);
	endfunction

	// Opcodes that carry an operand byte.
	function automatic logic has_operand(input logic [7:0] opc);
		return (opc >= OPC_JMP) && (opc <= OPC_REP);
	endfunction

endpackage

[hw/rtl/byte_stack_machine_core.sv]
// ----------------------------------------------------------------------------
// byte_stack_machine_core: 8-bit stack machine with program and stack RAMs
// Sequencer that fetches, decodes and executes one instruction per step item.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries op, load_address and
// load_byte. A load transfer writes one program byte, a start transfer clears
// the instruction, stack and frame pointers and begins a run, and a step
// transfer executes a single instruction while the machine runs. Every input
// transfer yields exactly one output transfer (out_valid/out_ready) carrying
// status, the value just below the stack pointer, and both pointers.
// From the accepting edge to out_valid: a load, a start or a step while not
// running only reads the top of the stack; an executed step passes through
// the opcode fetch (alone for halt and illegal opcode), the operand fetch, up
// to three stack reads in series, write back, then a top-of-stack read, RET
// being the longest. DIV and MOD also wait for the iterative divider; a zero
// divisor faults before the divider starts. The single-port program and stack
// RAMs force these steps in series; one item is processed at a time, and the
// next input transfer is taken the cycle after the result transfer.
// Reset clears the pointers, the argument count, the run flag and the status;
// the RAM contents are undefined until written. While the receiver stalls the
// result stays in the output register and a new item is taken only after
// the result transfer.
// ----------------------------------------------------------------------------
module byte_stack_machine_core #(
	parameter int PROGRAM_DEPTH = 256,
	parameter int STACK_DEPTH   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  load_address,
	input  logic [7:0]  load_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic signed [7:0] top_value,
	output logic [7:0]  instr_pointer,
	output logic [7:0]  stack_pointer
);
	import bsm_pkg::*;

	localparam int PAW = $clog2(PROGRAM_DEPTH);
	localparam int SAW = $clog2(STACK_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_OPC, S_OPND, S_RD1, S_RD2, S_DIV, S_EXEC, S_RET2, S_RET3,
		S_WR2, S_TOP, S_OUT
	} state_t;

	state_t     state_q;
	logic [7:0] ip_q, sp_q, bp_q, argc_q, opc_q, opnd_q, a_q, b_q, wr2_q;
	logic       run_q;
	status_t    status_q;

	// Program RAM port.
	logic           p_we;
	logic [PAW-1:0] p_addr;
	logic [7:0]     p_rdata;
	// Stack RAM port.
	logic           s_we;
	logic [7:0]     s_addr8;
	logic [7:0]     s_wdata;
	logic [7:0]     s_rdata;

	logic       div_start, div_done;
	logic [7:0] div_quo, div_rem;

	bsm_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(load_byte), .rdata(p_rdata));

	bsm_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(s_we), .addr(s_addr8[SAW-1:0]), .wdata(s_wdata), .rdata(s_rdata));

	bsm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(a_q), .divisor(b_q),
		.done(div_done), .quotient(div_quo), .remainder(div_rem));

	assign in_ready = (state_q == S_IDLE);
	wire in_xfer = in_valid && in_ready;
	wire [7:0] pc1 = ip_q + 8'd1;

	// The opcode fetch reads at ip, the operand fetch at ip+1.
	always_comb begin
		p_we   = in_xfer && (op == OP_LOAD);
		if (p_we) p_addr = load_address[PAW-1:0];
		else if (state_q == S_OPND) p_addr = pc1[PAW-1:0];
		else p_addr = ip_q[PAW-1:0];
	end

	// Binary/ALU result computed from a_q (second from top) and b_q (top).
	logic [7:0] alu_r;
	logic [15:0] prod;
	assign prod = 16'($signed(a_q) * $signed(b_q));
	always_comb begin
		unique case (opc_q)
			OPC_ADD: alu_r = a_q + b_q;
			OPC_SUB: alu_r = a_q - b_q;
			OPC_MUL: alu_r = prod[7:0];
			OPC_DIV: alu_r = div_quo;
			OPC_MOD: alu_r = div_rem;
			OPC_OR:  alu_r = a_q | b_q;
			OPC_XOR: alu_r = a_q ^ b_q;
			OPC_SHL: alu_r = (b_q >= 8'd8) ? 8'd0 : (a_q << b_q[2:0]);
			OPC_SHR: alu_r = (b_q >= 8'd8) ? {8{a_q[7]}} :
				8'($signed(a_q) >>> b_q[2:0]);
			OPC_EQ:  alu_r = {7'd0, a_q == b_q};
			OPC_NEQ: alu_r = {7'd0, a_q != b_q};
			OPC_LT:  alu_r = {7'd0, $signed(a_q) < $signed(b_q)};
			OPC_LE:  alu_r = {7'd0, $signed(a_q) <= $signed(b_q)};
			OPC_GT:  alu_r = {7'd0, $signed(a_q) > $signed(b_q)};
			OPC_GE:  alu_r = {7'd0, $signed(a_q) >= $signed(b_q)};
			default: alu_r = a_q;
		endcase
	end

	// Stack RAM port control: address and write per state.
	always_comb begin
		s_we    = 1'b0;
		s_addr8 = sp_q - 8'd1;
		s_wdata = alu_r;
		unique case (state_q)
			S_RD1: begin
				// In S_RD1 the top (or the frame entry for CPY) is being read.
				// The operand byte arrives from the program RAM in this cycle.
				if (opc_q == OPC_CPY) s_addr8 = bp_q + p_rdata;
				else s_addr8 = sp_q - 8'd1;
			end
			S_RD2: s_addr8 = (opc_q == OPC_RET) ? bp_q - 8'd1 : sp_q - 8'd2;
			S_DIV: if (opc_q == OPC_RET) s_addr8 = bp_q - 8'd2;
			S_EXEC: begin
				if (is_binary(opc_q)) begin
					s_we = 1'b1; s_addr8 = sp_q - 8'd2; s_wdata = alu_r;
				end else if (opc_q == OPC_NEG) begin
					s_we = 1'b1; s_addr8 = sp_q - 8'd1; s_wdata = 8'(-b_q);
				end else if (opc_q == OPC_NOT) begin
					s_we = 1'b1; s_addr8 = sp_q - 8'd1; s_wdata = ~b_q;
				end else if (opc_q == OPC_IMM) begin
					s_we = 1'b1; s_addr8 = sp_q; s_wdata = opnd_q;
				end else if (opc_q == OPC_CPY) begin
					s_we = 1'b1; s_addr8 = sp_q; s_wdata = b_q;
				end else if (opc_q == OPC_REP) begin
					s_we = 1'b1; s_addr8 = bp_q + opnd_q; s_wdata = b_q;
				end else if (opc_q == OPC_INV || opc_q == OPC_INVREL) begin
					s_we = 1'b1; s_addr8 = sp_q; s_wdata = bp_q;
				end
			end
			S_WR2: begin
				// The divide path passes through here only to start the divider.
				if (opc_q != OPC_DIV && opc_q != OPC_MOD) begin
					s_we = 1'b1; s_addr8 = sp_q; s_wdata = wr2_q;
				end
			end
			S_RET3: begin
				if (opc_q == OPC_RET) begin
					s_we = 1'b1; s_addr8 = bp_q - 8'd2 - argc_q; s_wdata = b_q;
				end
			end
			S_TOP: s_addr8 = sp_q - 8'd1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ip_q     <= '0;
			sp_q     <= '0;
			bp_q     <= '0;
			argc_q   <= '0;
			run_q    <= 1'b0;
			status_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						priority case (op)
							OP_START: begin
								ip_q <= '0; sp_q <= '0; bp_q <= '0;
								run_q <= 1'b1; status_q <= ST_RUNNING;
								state_q <= S_TOP;
							end
							OP_STEP: state_q <= run_q ? S_OPC : S_TOP;
							default: state_q <= S_TOP;
						endcase
					end
				end
				S_OPC: begin
					// Program RAM read at ip was issued in the previous cycle.
					state_q <= S_OPND;
				end
				S_OPND: begin
					opc_q <= p_rdata;
					ip_q  <= pc1;
					if (has_operand(p_rdata)) begin
						state_q <= S_RD1; // operand read at new ip issued now
					end else if (p_rdata == OPC_HLT) begin
						run_q <= 1'b0; status_q <= ST_HALTED; state_q <= S_TOP;
					end else if (p_rdata > OPC_RET) begin
						run_q <= 1'b0; status_q <= ST_ILLEGAL; state_q <= S_TOP;
					end else begin
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					if (has_operand(opc_q)) begin
						opnd_q <= p_rdata;
						ip_q   <= pc1;
					end
					state_q <= S_RD2;
				end
				S_RD2: begin
					// Data of the first stack read arrives now.
					b_q <= s_rdata;
					if (is_binary(opc_q) || opc_q == OPC_RET) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_DIV: begin
					if (opc_q == OPC_RET) begin
						a_q <= s_rdata; // saved ip
						state_q <= S_RET2;
					end else if (opc_q == OPC_DIV || opc_q == OPC_MOD) begin
						a_q <= s_rdata;
						if (b_q == 8'd0) begin
							run_q <= 1'b0; status_q <= ST_DIVZERO; state_q <= S_TOP;
						end else begin
							state_q <= S_WR2; wr2_q <= 8'hFF; // marker: divider start
						end
					end else begin
						a_q <= s_rdata;
						state_q <= S_EXEC;
					end
				end
				S_WR2: begin
					if (wr2_q == 8'hFF && (opc_q == OPC_DIV || opc_q == OPC_MOD)) begin
						wr2_q <= 8'h00;
						state_q <= S_RET3; // wait in divider
					end else begin
						sp_q <= sp_q + 8'd1;
						state_q <= S_TOP;
					end
				end
				S_RET2: begin
					// Saved bp arrives from the read issued at bp-2 in S_DIV.
					wr2_q   <= s_rdata;
					state_q <= S_RET3;
				end
				S_RET3: begin
					if (opc_q == OPC_RET) begin
						ip_q <= a_q;
						bp_q <= wr2_q;
						sp_q <= bp_q - 8'd1 - argc_q;
						state_q <= S_TOP;
					end else if (div_done) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_TOP;
					if (is_binary(opc_q)) sp_q <= sp_q - 8'd1;
					else unique case (opc_q)
						OPC_JMP:     ip_q <= opnd_q;
						OPC_JMPREL:  ip_q <= ip_q + opnd_q;
						OPC_JMPF:    begin sp_q <= sp_q - 8'd1; if (b_q == 8'd0) ip_q <= opnd_q; end
						OPC_JMPFREL: begin sp_q <= sp_q - 8'd1; if (b_q == 8'd0) ip_q <= ip_q + opnd_q; end
						OPC_JMPT:    begin sp_q <= sp_q - 8'd1; if (b_q != 8'd0) ip_q <= opnd_q; end
						OPC_JMPTREL: begin sp_q <= sp_q - 8'd1; if (b_q != 8'd0) ip_q <= ip_q + opnd_q; end
						OPC_IMM, OPC_CPY: sp_q <= sp_q + 8'd1;
						OPC_ARG:     argc_q <= opnd_q;
						OPC_REP:     sp_q <= sp_q - 8'd1;
						OPC_INV, OPC_INVREL: begin
							sp_q  <= sp_q + 8'd1;
							wr2_q <= ip_q;
							bp_q  <= sp_q + 8'd2;
							ip_q  <= (opc_q == OPC_INV) ? opnd_q : ip_q + opnd_q;
							state_q <= S_WR2;
						end
						default: ;
					endcase
				end
				S_TOP: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid) begin
						out_valid     <= 1'b1;
						status        <= status_q;
						top_value     <= (sp_q == 8'd0) ? 8'sd0 : $signed(s_rdata);
						instr_pointer <= ip_q;
						stack_pointer <= sp_q;
					end else if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The divider starts as the operands settle.
	assign div_start = (state_q == S_WR2) && (wr2_q == 8'hFF) &&
		(opc_q == OPC_DIV || opc_q == OPC_MOD);

	property p_one_result;
		@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready;
	endproperty
	a_one_result: assert property (p_one_result) else $error("item taken while result pending");

	a_stack_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_we |-> !in_ready) else $error("stack write while idle");

	a_halt_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q != ST_RUNNING && status_q != ST_IDLE) |-> !run_q)
		else $error("faulted but still running");
endmodule

[hw/rtl/bsm_ram.sv]
// ----------------------------------------------------------------------------
// bsm_ram: generic single-port synchronous RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module bsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

[hw/rtl/bsm_div.sv]
// ----------------------------------------------------------------------------
// bsm_div: signed 8-bit iterative divider
// Restoring division, one quotient bit per cycle; truncating C semantics.
// ----------------------------------------------------------------------------
module bsm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic signed [7:0] dividend,
	input  logic signed [7:0] divisor,
	output logic              done,
	output logic [7:0]        quotient,
	output logic [7:0]        remainder
);
	logic [7:0] quo_q;
	logic [8:0] rem_q;
	logic [7:0] dvs_q;
	logic [3:0] cnt_q;
	logic       busy_q;
	logic       qneg_q;
	logic       rneg_q;
	logic [8:0] trial;
	logic [8:0] shifted;

	assign shifted = {rem_q[7:0], quo_q[7]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd8;
				quo_q  <= dividend[7] ? 8'(-dividend) : dividend;
				dvs_q  <= divisor[7] ? 8'(-divisor) : divisor;
				rem_q  <= '0;
				qneg_q <= dividend[7] ^ divisor[7];
				rneg_q <= dividend[7];
			end else if (busy_q) begin
				if (trial[8]) begin
					rem_q <= shifted;
					quo_q <= {quo_q[6:0], 1'b0};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[6:0], 1'b1};
				end
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quotient  = qneg_q ? 8'(-quo_q) : quo_q;
	assign remainder = rneg_q ? 8'(-rem_q[7:0]) : rem_q[7:0];
endmodule

[dv/byte_stack_machine_core_tb.sv]
// ----------------------------------------------------------------------------
// byte_stack_machine_core_tb: self-checking bench for the byte stack machine
// Drives load, start and step transfers with bursty input and a stalling
// output side, predicts every result with a cycle-free model of the machine
// and compares each output transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module byte_stack_machine_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsm_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 415;

	// One stimulus row; typed rows carry an expectation written out by hand.
	typedef struct {
		item_op_t          op;
		logic [7:0]        addr;
		logic [7:0]        data;
		bit                typed;
		status_t           st;
		logic signed [7:0] top;
		logic [7:0]        ip;
		logic [7:0]        sp;
	} stim_row_t;

	typedef struct {
		status_t           st;
		logic signed [7:0] top;
		logic [7:0]        ip;
		logic [7:0]        sp;
	} machine_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = 2'd0;
	logic [7:0] load_address = 8'd0;
	logic [7:0] load_byte = 8'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic signed [7:0] top_value;
	logic [7:0] instr_pointer;
	logic [7:0] stack_pointer;

	byte_stack_machine_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .load_address(load_address), .load_byte(load_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .top_value(top_value),
		.instr_pointer(instr_pointer), .stack_pointer(stack_pointer)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the machine state.
	logic [7:0] shadow_prog [256];
	logic [7:0] shadow_stack [256];
	logic [7:0] m_ip, m_sp, m_bp, m_argc;
	bit         m_run;
	status_t    m_status;

	stim_row_t     stim_q [$];
	machine_view_t expected_q [$];
	int            accept_idx = 0;
	int            error_count = 0;
	int            cyc = 0;

	function automatic int sx(input logic [7:0] v);
		return int'($signed(v));
	endfunction

	function automatic logic [7:0] fetch_prog();
		logic [7:0] v;
		v = shadow_prog[m_ip];
		m_ip = m_ip + 8'd1;
		return v;
	endfunction

	function automatic void push_val(input logic [7:0] v);
		shadow_stack[m_sp] = v;
		m_sp = m_sp + 8'd1;
	endfunction

	function automatic logic [7:0] pop_val();
		m_sp = m_sp - 8'd1;
		return shadow_stack[m_sp];
	endfunction

	// Executes one instruction on the shadow state.
	function automatic void run_instruction();
		logic [7:0] opc, t, u, x;
		int a, b, r;
		bit take;
		opc = fetch_prog();
		r = 0;
		if (opc >= OPC_ADD && opc <= OPC_GE && opc != OPC_NEG && opc != OPC_NOT) begin
			b = sx(shadow_stack[8'(m_sp - 8'd1)]);
			a = sx(shadow_stack[8'(m_sp - 8'd2)]);
			if ((opc == OPC_DIV || opc == OPC_MOD) && b == 0) begin
				m_run = 1'b0;
				m_status = ST_DIVZERO;
				return;
			end
			m_sp = m_sp - 8'd2;
			u = b[7:0];
			case (opc)
				OPC_ADD: r = a + b;
				OPC_SUB: r = a - b;
				OPC_MUL: r = a * b;
				OPC_DIV: r = a / b;
				OPC_MOD: r = a % b;
				OPC_OR:  r = a | b;
				OPC_XOR: r = a ^ b;
				OPC_SHL: begin
					x = a[7:0] << u;
					r = (u >= 8) ? 0 : int'(x);
				end
				OPC_SHR: r = (u >= 8) ? ((a < 0) ? -1 : 0) : (a >>> u);
				OPC_EQ:  r = int'(a == b);
				OPC_NEQ: r = int'(a != b);
				OPC_LT:  r = int'(a < b);
				OPC_LE:  r = int'(a <= b);
				OPC_GT:  r = int'(a > b);
				default: r = int'(a >= b);
			endcase
			push_val(r[7:0]);
			return;
		end
		case (opc)
			OPC_HLT: begin
				m_run = 1'b0;
				m_status = ST_HALTED;
			end
			OPC_NEG: begin
				t = pop_val();
				push_val(8'd0 - t);
			end
			OPC_NOT: begin
				t = pop_val();
				push_val(~t);
			end
			OPC_JMP: m_ip = fetch_prog();
			OPC_JMPREL: begin
				t = fetch_prog();
				m_ip = m_ip + t;
			end
			OPC_JMPF, OPC_JMPFREL, OPC_JMPT, OPC_JMPTREL: begin
				// The condition is popped and the operand is consumed either way.
				t = pop_val();
				take = (opc <= OPC_JMPFREL) ? (t == 8'd0) : (t != 8'd0);
				u = fetch_prog();
				if (take) begin
					if (opc == OPC_JMPF || opc == OPC_JMPT) m_ip = u;
					else m_ip = m_ip + u;
				end
			end
			OPC_IMM: push_val(fetch_prog());
			OPC_INV, OPC_INVREL: begin
				t = fetch_prog();
				push_val(m_bp);
				push_val(m_ip);
				m_bp = m_sp;
				if (opc == OPC_INV) m_ip = t;
				else m_ip = m_ip + t;
			end
			OPC_CPY: begin
				t = fetch_prog();
				push_val(shadow_stack[8'(m_bp + t)]);
			end
			OPC_ARG: m_argc = fetch_prog();
			OPC_REP: begin
				t = pop_val();
				u = fetch_prog();
				shadow_stack[8'(m_bp + u)] = t;
			end
			OPC_RET: begin
				t = pop_val();
				m_sp = m_bp;
				m_ip = pop_val();
				m_bp = pop_val();
				m_sp = m_sp - m_argc;
				push_val(t);
			end
			default: begin
				m_run = 1'b0;
				m_status = ST_ILLEGAL;
			end
		endcase
	endfunction

	function automatic machine_view_t apply_item(input logic [1:0] iop,
		input logic [7:0] iaddr, input logic [7:0] idata);
		machine_view_t v;
		case (iop)
			OP_LOAD: shadow_prog[iaddr] = idata;
			OP_START: begin
				m_ip = 8'd0;
				m_sp = 8'd0;
				m_bp = 8'd0;
				m_run = 1'b1;
				m_status = ST_RUNNING;
			end
			OP_STEP: if (m_run) run_instruction();
			default: ;
		endcase
		v.st = m_status;
		v.top = (m_sp == 8'd0) ? 8'sd0 : $signed(shadow_stack[8'(m_sp - 8'd1)]);
		v.ip = m_ip;
		v.sp = m_sp;
		return v;
	endfunction

	function automatic void add_row(input item_op_t o, input logic [7:0] a,
		input logic [7:0] d);
		stim_row_t r;
		r.op = o;
		r.addr = a;
		r.data = d;
		r.typed = 1'b0;
		r.st = ST_IDLE;
		r.top = 8'sd0;
		r.ip = 8'd0;
		r.sp = 8'd0;
		stim_q.push_back(r);
	endfunction

	function automatic void add_typed(input item_op_t o, input logic [7:0] a,
		input logic [7:0] d, input status_t s, input logic [7:0] tv,
		input logic [7:0] ipv, input logic [7:0] spv);
		stim_row_t r;
		r.op = o;
		r.addr = a;
		r.data = d;
		r.typed = 1'b1;
		r.st = s;
		r.top = $signed(tv);
		r.ip = ipv;
		r.sp = spv;
		stim_q.push_back(r);
	endfunction

	// Program bytes lean on opcodes and on edge values of operands.
	function automatic logic [7:0] program_byte();
		int pick;
		logic [7:0] edges [8];
		edges = '{8'h00, 8'h01, 8'hFF, 8'h07, 8'h08, 8'h7F, 8'h80, 8'h81};
		pick = $urandom_range(0, 99);
		if (pick < 55) return 8'($urandom_range(0, 30));
		if (pick < 62) return 8'($urandom_range(31, 255));
		if (pick < 82) return edges[$urandom_range(0, 7)];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic build_stimulus();
		int produced, len, base, k;
		// Directed table: idle reporting, field extremes, the divide overflow
		// wrap and the divide-by-zero fault with the step that follows it.
		add_typed(OP_STEP,  8'h00, 8'h00, ST_IDLE, 8'h00, 8'h00, 8'h00);
		add_typed(OP_NONE,  8'hFF, 8'hFF, ST_IDLE, 8'h00, 8'h00, 8'h00);
		add_typed(OP_LOAD,  8'hFF, 8'h00, ST_IDLE, 8'h00, 8'h00, 8'h00);
		add_typed(OP_LOAD,  8'h00, 8'hFF, ST_IDLE, 8'h00, 8'h00, 8'h00);
		add_row(OP_LOAD, 8'd0, OPC_IMM);
		add_row(OP_LOAD, 8'd1, 8'h80);
		add_row(OP_LOAD, 8'd2, OPC_IMM);
		add_row(OP_LOAD, 8'd3, 8'hFF);
		add_row(OP_LOAD, 8'd4, OPC_DIV);
		add_row(OP_LOAD, 8'd5, OPC_IMM);
		add_row(OP_LOAD, 8'd6, 8'h00);
		add_row(OP_LOAD, 8'd7, OPC_DIV);
		add_typed(OP_START, 8'h00, 8'h00, ST_RUNNING, 8'h00, 8'h00, 8'h00);
		add_row(OP_STEP, 8'd0, 8'd0);
		add_row(OP_STEP, 8'd0, 8'd0);
		add_typed(OP_STEP, 8'h00, 8'h00, ST_RUNNING, 8'h80, 8'd5, 8'd1);
		add_row(OP_STEP, 8'd0, 8'd0);
		add_typed(OP_STEP, 8'h00, 8'h00, ST_DIVZERO, 8'h00, 8'd8, 8'd2);
		add_typed(OP_STEP, 8'h00, 8'h00, ST_DIVZERO, 8'h00, 8'd8, 8'd2);

		// Fill every program byte with a run of IMMs closed by a JMP back to
		// zero, then step until the stack pointer has wrapped once, so that no
		// later read touches an unwritten entry.
		for (int i = 0; i < 256; i++) begin
			if (i == 254) add_row(OP_LOAD, 8'(i), OPC_JMP);
			else if (i == 255) add_row(OP_LOAD, 8'(i), 8'd0);
			else if (i % 2 == 0) add_row(OP_LOAD, 8'(i), OPC_IMM);
			else add_row(OP_LOAD, 8'(i), 8'($urandom_range(0, 255)));
		end
		add_row(OP_START, 8'd0, 8'd0);
		for (int i = 0; i < 260; i++) add_row(OP_STEP, 8'd0, 8'd0);

		// Random part: mostly short programs that are loaded, started and
		// stepped, mixed with stray items of any op.
		produced = 0;
		while (produced < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 85) begin
				len = $urandom_range(4, 24);
				base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0;
				for (k = 0; k < len; k++) add_row(OP_LOAD, 8'(base + k), program_byte());
				add_row(OP_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				k = $urandom_range(10, 40);
				for (int s = 0; s < k; s++)
					add_row(OP_STEP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				produced += len + 1 + k;
			end else begin
				add_row(item_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				produced++;
			end
		end
	endtask

	// Monitor: every accepted input produces one expectation; every output
	// transfer is checked against the oldest one.
	always @(posedge clk) begin
		machine_view_t pred, got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pred = apply_item(op, load_address, load_byte);
				if (stim_q[accept_idx].typed) begin
					pred.st = stim_q[accept_idx].st;
					pred.top = stim_q[accept_idx].top;
					pred.ip = stim_q[accept_idx].ip;
					pred.sp = stim_q[accept_idx].sp;
				end
				accept_idx++;
				expected_q.push_back(pred);
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with no item outstanding");
					error_count++;
				end else begin
					got = expected_q.pop_front();
					if (status !== got.st) begin
						$error("status: expected %0d, got %0d", got.st, status);
						error_count++;
					end
					if (top_value !== got.top) begin
						$error("top_value: expected %0d, got %0d", got.top, top_value);
						error_count++;
					end
					if (instr_pointer !== got.ip) begin
						$error("instr_pointer: expected %0d, got %0d", got.ip, instr_pointer);
						error_count++;
					end
					if (stack_pointer !== got.sp) begin
						$error("stack_pointer: expected %0d, got %0d", got.sp, stack_pointer);
						error_count++;
					end
				end
			end
		end
	end

	// Receiver: the stall pattern changes in turn between always ready, coin flips,
	// a fixed rhythm and long stalls.
	always @(negedge clk) begin
		case ((cyc / 300) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 1);
			2: out_ready <= ((cyc % 5) >= 2);
			default: out_ready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("byte_stack_machine_core_tb: done, errors");
			$finish;
		end
	end

	// Sender: bursts of back-to-back transfers separated by random gaps.
	initial begin
		int burst_left, gap;
		build_stimulus();
		m_ip = 8'd0;
		m_sp = 8'd0;
		m_bp = 8'd0;
		m_argc = 8'd0;
		m_run = 1'b0;
		m_status = ST_IDLE;
		foreach (shadow_prog[i]) shadow_prog[i] = 8'd0;
		foreach (shadow_stack[i]) shadow_stack[i] = 8'd0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		burst_left = 0;
		foreach (stim_q[i]) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst_left = $urandom_range(1, 12);
			end
			op <= stim_q[i].op;
			load_address <= stim_q[i].addr;
			load_byte <= stim_q[i].data;
			in_valid <= 1'b1;
			do @(posedge clk); while (!in_ready);
			@(negedge clk);
			burst_left--;
		end
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (error_count == 0) begin
			$display("byte_stack_machine_core_tb: done, clean");
		end else begin
			$display("byte_stack_machine_core_tb: done, errors");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_ram.sv
hw/rtl/bsm_div.sv
hw/rtl/byte_stack_machine_core.sv
dv/byte_stack_machine_core_tb.sv
